### src/ucv_pkg.sv
`default_nettype none
package ucv_pkg;

    localparam logic [2:0] MODE_USER   = 3'd0;
    localparam logic [2:0] MODE_HOST   = 3'd1;
    localparam logic [2:0] MODE_PATH   = 3'd2;
    localparam logic [2:0] MODE_QUERY  = 3'd3;
    localparam logic [2:0] MODE_SCHEME = 3'd4;

    localparam logic [1:0] REG_MODE        = 2'd0;
    localparam logic [1:0] REG_COLON_FIRST = 2'd1;
    localparam logic [1:0] REG_EMPTY_PATH  = 2'd2;

    localparam int unsigned PADDR_W = 4;

    localparam logic [8:0] OCTET_MAX = 9'd255;
    localparam logic [8:0] OCTET_SAT = 9'd256;

    typedef struct packed {
        logic [2:0] component_mode;
        logic       colon_first_segment_ok;
        logic       empty_path_ok;
    } cfg_t;

    typedef struct packed {
        logic digit;
        logic alpha;
        logic hex;
        logic unreserved;
        logic subdelim;
        logic pchar;
    } char_class_t;

    typedef struct packed {
        logic valid_res;
        logic host_is_ipv4;
    } result_t;

endpackage
`default_nettype wire

### src/ucv_cfg.sv
`default_nettype none
module ucv_cfg
    import ucv_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.component_mode         <= MODE_USER;
            cfg_reg.colon_first_segment_ok <= 1'b1;
            cfg_reg.empty_path_ok          <= 1'b1;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MODE:        cfg_reg.component_mode         <= pwdata[2:0];
                REG_COLON_FIRST: cfg_reg.colon_first_segment_ok <= pwdata[0];
                REG_EMPTY_PATH:  cfg_reg.empty_path_ok          <= pwdata[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MODE:        prdata = {29'd0, cfg_reg.component_mode};
            REG_COLON_FIRST: prdata = {31'd0, cfg_reg.colon_first_segment_ok};
            REG_EMPTY_PATH:  prdata = {31'd0, cfg_reg.empty_path_ok};
            default:         prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

### src/ucv_char_class.sv
`default_nettype none
module ucv_char_class
    import ucv_pkg::*;
(
    input  wire logic [7:0] ch,
    output char_class_t     cls
);

    logic digit;
    logic lower;
    logic upper;
    logic subdelim;
    logic unreserved;

    assign digit = (ch >= 8'h30) && (ch <= 8'h39);
    assign lower = (ch >= 8'h61) && (ch <= 8'h7a);
    assign upper = (ch >= 8'h41) && (ch <= 8'h5a);

    assign subdelim = (ch == 8'h21) || (ch == 8'h24) || (ch == 8'h26) || (ch == 8'h27) ||
                      (ch == 8'h28) || (ch == 8'h29) || (ch == 8'h2a) || (ch == 8'h2b) ||
                      (ch == 8'h2c) || (ch == 8'h3b) || (ch == 8'h3d);

    assign unreserved = digit || lower || upper || (ch == 8'h2d) || (ch == 8'h2e) ||
                        (ch == 8'h5f) || (ch == 8'h7e);

    assign cls.digit      = digit;
    assign cls.alpha      = lower || upper;
    assign cls.hex        = digit || ((ch >= 8'h61) && (ch <= 8'h66)) ||
                            ((ch >= 8'h41) && (ch <= 8'h46));
    assign cls.unreserved = unreserved;
    assign cls.subdelim   = subdelim;
    assign cls.pchar      = unreserved || subdelim || (ch == 8'h3a) || (ch == 8'h40);

endmodule
`default_nettype wire

### src/ucv_core.sv
`default_nettype none
module ucv_core
    import ucv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [7:0]  ch,
    input  wire logic        end_mark,
    input  wire char_class_t cls,
    input  wire cfg_t        cfg,
    output result_t          res
);

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_QMARK = 8'h3f;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_DASH  = 8'h2d;

    logic       failed_reg,          failed_next;
    logic       seen_char_reg,       seen_char_next;
    logic [1:0] escape_left_reg,     escape_left_next;
    logic       maybe_ipv4_reg,      maybe_ipv4_next;
    logic [1:0] dot_count_reg,       dot_count_next;
    logic [8:0] octet_value_reg,     octet_value_next;
    logic       octet_has_digit_reg, octet_has_digit_next;
    logic       need_segment_reg,    need_segment_next;
    logic       colon_ok_reg,        colon_ok_next;

    logic [11:0] octet_sum;
    logic        colon_eff;
    logic        ok;

    assign octet_sum = {octet_value_reg, 3'b000} + {2'b00, octet_value_reg, 1'b0}
                     + {8'd0, ch[3:0]};
    assign colon_eff = seen_char_reg ? colon_ok_reg : cfg.colon_first_segment_ok;

    always_comb
    begin
        failed_next          = failed_reg;
        seen_char_next       = seen_char_reg;
        escape_left_next     = escape_left_reg;
        maybe_ipv4_next      = maybe_ipv4_reg;
        dot_count_next       = dot_count_reg;
        octet_value_next     = octet_value_reg;
        octet_has_digit_next = octet_has_digit_reg;
        need_segment_next    = need_segment_reg;
        colon_ok_next        = colon_ok_reg;

        if (!failed_reg)
        begin
            if (escape_left_reg != 2'd0)
            begin
                failed_next      = !cls.hex;
                escape_left_next = escape_left_reg - 2'd1;
            end
            else
            begin
                case (cfg.component_mode)
                    MODE_USER:
                    begin
                        if (ch == CH_PCT)
                            escape_left_next = 2'd2;
                        else if (!(cls.unreserved || cls.subdelim || ch == CH_COLON))
                            failed_next = 1'b1;
                    end
                    MODE_HOST:
                    begin
                        if (cls.unreserved)
                        begin
                            if (maybe_ipv4_reg)
                            begin
                                if (cls.digit)
                                begin
                                    octet_value_next = (octet_sum > {3'd0, OCTET_SAT}) ?
                                                       OCTET_SAT : octet_sum[8:0];
                                    octet_has_digit_next = 1'b1;
                                end
                                else if (ch == CH_DOT && octet_has_digit_reg &&
                                         dot_count_reg != 2'd3 &&
                                         octet_value_reg <= OCTET_MAX)
                                begin
                                    dot_count_next       = dot_count_reg + 2'd1;
                                    octet_value_next     = 9'd0;
                                    octet_has_digit_next = 1'b0;
                                end
                                else
                                    maybe_ipv4_next = 1'b0;
                            end
                        end
                        else if (cls.subdelim)
                            maybe_ipv4_next = 1'b0;
                        else if (ch == CH_PCT)
                        begin
                            maybe_ipv4_next  = 1'b0;
                            escape_left_next = 2'd2;
                        end
                        else
                            failed_next = 1'b1;
                    end
                    MODE_PATH:
                    begin
                        colon_ok_next = colon_eff;
                        if (ch == CH_SLASH)
                        begin
                            if (seen_char_reg && need_segment_reg)
                                failed_next = 1'b1;
                            need_segment_next = 1'b1;
                            colon_ok_next     = 1'b1;
                        end
                        else
                        begin
                            need_segment_next = 1'b0;
                            if (ch == CH_COLON && !colon_eff)
                                failed_next = 1'b1;
                            else if (ch == CH_PCT)
                                escape_left_next = 2'd2;
                            else if (!cls.pchar)
                                failed_next = 1'b1;
                        end
                    end
                    MODE_QUERY:
                    begin
                        if (ch == CH_PCT)
                            escape_left_next = 2'd2;
                        else if (!(cls.pchar || ch == CH_SLASH || ch == CH_QMARK))
                            failed_next = 1'b1;
                    end
                    MODE_SCHEME:
                    begin
                        if (!seen_char_reg)
                            failed_next = !cls.alpha;
                        else if (!(cls.alpha || cls.digit || ch == CH_PLUS ||
                                   ch == CH_DASH || ch == CH_DOT))
                            failed_next = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
        seen_char_next = 1'b1;

        if (end_mark)
        begin
            failed_next          = 1'b0;
            seen_char_next       = 1'b0;
            escape_left_next     = 2'd0;
            maybe_ipv4_next      = 1'b1;
            dot_count_next       = 2'd0;
            octet_value_next     = 9'd0;
            octet_has_digit_next = 1'b0;
            need_segment_next    = 1'b1;
            colon_ok_next        = 1'b0;
        end
    end

    always_comb
    begin
        ok = !failed_reg && (escape_left_reg == 2'd0);
        case (cfg.component_mode)
            MODE_USER:   ok = ok;
            MODE_QUERY:  ok = ok;
            MODE_HOST:   ok = ok && seen_char_reg;
            MODE_SCHEME: ok = ok && seen_char_reg;
            MODE_PATH:   ok = seen_char_reg ? ok : cfg.empty_path_ok;
            default:     ok = 1'b0;
        endcase
        res.valid_res    = ok;
        res.host_is_ipv4 = ok && (cfg.component_mode == MODE_HOST) && maybe_ipv4_reg &&
                           (dot_count_reg == 2'd3) && octet_has_digit_reg &&
                           (octet_value_reg <= OCTET_MAX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            failed_reg          <= 1'b0;
            seen_char_reg       <= 1'b0;
            escape_left_reg     <= 2'd0;
            maybe_ipv4_reg      <= 1'b1;
            dot_count_reg       <= 2'd0;
            octet_value_reg     <= 9'd0;
            octet_has_digit_reg <= 1'b0;
            need_segment_reg    <= 1'b1;
            colon_ok_reg        <= 1'b0;
        end
        else if (step)
        begin
            failed_reg          <= failed_next;
            seen_char_reg       <= seen_char_next;
            escape_left_reg     <= escape_left_next;
            maybe_ipv4_reg      <= maybe_ipv4_next;
            dot_count_reg       <= dot_count_next;
            octet_value_reg     <= octet_value_next;
            octet_has_digit_reg <= octet_has_digit_next;
            need_segment_reg    <= need_segment_next;
            colon_ok_reg        <= colon_ok_next;
        end
    end

endmodule
`default_nettype wire

### src/uri_component_validator.sv
`default_nettype none
// URI component validator (RFC 3986 character rules).
// Input channel: one beat per character (ch), or an end beat (end_mark = 1)
// that closes the component. Output channel: one beat per end beat, carrying
// valid_res and host_is_ipv4. Character beats produce no output.
// The APB port selects the grammar (component_mode) and the path options;
// write it only while no component is in flight.
// Throughput: one beat per cycle unless the receiver stalls an end beat.
// Each beat is captured in an input register, then checked against the running
// component state; the state update is the loop that sets this rate.
// An accepted end beat passes from the input register into the result
// register, which raises out_valid until the result is taken.
// When the receiver stalls, the result register holds; character beats keep
// flowing, and a second end beat waits in the input register, holding
// in_ready low, until the result is taken.
// Reset: registers return to userinfo mode with both path options set, the
// component state clears, and both channels come up empty.
module uri_component_validator
    import ucv_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         ch,
    input  wire logic               end_mark,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    valid_res,
    output logic                    host_is_ipv4,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    cfg_t        cfg;
    char_class_t cls;
    result_t     res;
    result_t     res_reg;

    logic       item_vld_reg;
    logic [7:0] ch_reg;
    logic       end_reg;
    logic       out_vld_reg;
    logic       step;

    assign step     = item_vld_reg && (!end_reg || !out_vld_reg || out_ready);
    assign in_ready = !item_vld_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_vld_reg <= 1'b0;
        else if (in_ready)
            item_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            ch_reg  <= ch;
            end_reg <= end_mark;
        end
    end

    ucv_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ucv_char_class u_class (
        .ch  (ch_reg),
        .cls (cls)
    );

    ucv_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .ch       (ch_reg),
        .end_mark (end_reg),
        .cls      (cls),
        .cfg      (cfg),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (step && end_reg)
            out_vld_reg <= 1'b1;
        else if (out_ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && end_reg)
            res_reg <= res;
    end

    assign out_valid    = out_vld_reg;
    assign valid_res    = res_reg.valid_res;
    assign host_is_ipv4 = res_reg.host_is_ipv4;

    a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> item_vld_reg && end_reg && out_vld_reg)
        else $error("input stalled without a pending end beat");

    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        step && end_reg |=> out_vld_reg)
        else $error("end beat produced no result");

    a_ipv4_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && res_reg.host_is_ipv4 |-> res_reg.valid_res)
        else $error("ipv4 flag on an invalid host");

endmodule
`default_nettype wire
